FILE: hdl/acg_pkg.sv
`default_nettype none

package acg_pkg;

    // Savings threshold in percent and the divisor that follows from it.
    localparam int unsigned SavePct = 5;
    localparam int unsigned SaveDivRaw = 100 / SavePct;
    localparam int unsigned SaveDiv = (SaveDivRaw == 0) ? 1 : SaveDivRaw;

    // Widths of the configuration port.
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    // Register indexes on the configuration port.
    localparam logic [CfgIdxW-1:0] CFG_ADAPTIVE_ENABLE = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_SAMPLE_BYTES = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_OFF_SECONDS = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_SECONDS = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LENGTH_THRESHOLD = 3'd4;

    // Register values after reset.
    localparam logic RST_ADAPTIVE_ENABLE = 1'b1;
    localparam logic [31:0] RST_MIN_SAMPLE_BYTES = 32'd1000;
    localparam logic [15:0] RST_OFF_SECONDS = 16'd60;
    localparam logic [15:0] RST_SAMPLE_SECONDS = 16'd2;
    localparam logic [15:0] RST_LENGTH_THRESHOLD = 16'd100;

    // Action codes.
    localparam logic [1:0] ACT_EMPTY = 2'd0;
    localparam logic [1:0] ACT_COMPRESSED = 2'd1;
    localparam logic [1:0] ACT_RAW = 2'd2;
    localparam logic [1:0] ACT_DROP = 2'd3;

    // Header bytes.
    localparam logic [7:0] HDR_COMPRESSED = 8'h66;
    localparam logic [7:0] HDR_RAW = 8'hFA;
    localparam logic [7:0] HDR_NONE = 8'h00;

    typedef struct packed {
        logic [31:0] time_seconds;
        logic [15:0] packet_length;
        logic [16:0] compressed_length;
        logic        compressor_error;
    } t_in_item;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] header_byte;
        logic       attempted;
    } t_out_item;

    typedef struct packed {
        logic        adaptive_enable;
        logic [31:0] min_sample_bytes;
        logic [15:0] off_seconds;
        logic [15:0] sample_seconds;
        logic [15:0] length_threshold;
    } t_cfg;

endpackage

`default_nettype wire

FILE: hdl/acg_gate.sv
`default_nettype none

module acg_gate (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire acg_pkg::t_cfg     i_cfg,
    input  wire logic              i_step,
    input  wire acg_pkg::t_in_item i_item,
    output acg_pkg::t_out_item     o_result
);
    import acg_pkg::*;

    localparam int unsigned ScaleW = 33 + $clog2(SaveDiv + 1);

    logic        r_off;
    logic [31:0] r_deadline;
    logic [31:0] r_total;
    logic [31:0] r_comp;
    logic        n_off;
    logic [31:0] n_deadline;
    logic [31:0] n_total;
    logic [31:0] n_comp;

    logic              due;
    logic              poor;
    logic [32:0]       saved;
    logic [32:0]       saved_plus1;
    logic [ScaleW-1:0] scaled;
    logic              approve;
    logic [31:0]       base_total;
    logic [31:0]       base_comp;
    logic [32:0]       sum_total;
    logic [32:0]       sum_comp;
    logic              is_empty;
    logic              long_enough;

    // Savings test: saved < total / div, written as div * (saved + 1) <= total for
    // non-negative savings; expansion is poor too. Both need total > min_sample_bytes.
    always_comb begin
        saved = {1'b0, r_total} - {1'b0, r_comp};
        saved_plus1 = saved + 33'd1;
        scaled = ScaleW'(saved_plus1) * ScaleW'(SaveDiv);
        poor = (r_total > i_cfg.min_sample_bytes) &&
               (saved[32] || (scaled <= ScaleW'(r_total)));
        due = i_item.time_seconds >= r_deadline;
    end

    // Gate step, totals and result for the request in the input register.
    always_comb begin
        n_off = r_off;
        n_deadline = r_deadline;
        n_total = r_total;
        n_comp = r_comp;
        approve = 1'b1;
        base_total = r_total;
        base_comp = r_comp;
        is_empty = i_item.packet_length == 16'd0;
        long_enough = i_item.packet_length >= i_cfg.length_threshold;

        if (i_cfg.adaptive_enable && !is_empty && long_enough) begin
            if (due) begin
                base_total = 32'd0;
                base_comp = 32'd0;
                if (!r_off && poor) begin
                    n_off = 1'b1;
                    n_deadline = i_item.time_seconds + 32'(i_cfg.off_seconds);
                end else begin
                    n_off = 1'b0;
                    n_deadline = i_item.time_seconds + 32'(i_cfg.sample_seconds);
                end
            end else begin
                n_off = r_off;
            end
            approve = !n_off;
            n_total = base_total;
            n_comp = base_comp;
        end

        // Saturating totals for an approved, error-free attempt.
        sum_total = {1'b0, base_total} + 33'(i_item.packet_length);
        sum_comp = {1'b0, base_comp} + 33'(i_item.compressed_length);
        if (i_cfg.adaptive_enable && !is_empty && long_enough && approve &&
            !i_item.compressor_error) begin
            n_total = sum_total[32] ? 32'hFFFF_FFFF : sum_total[31:0];
            n_comp = sum_comp[32] ? 32'hFFFF_FFFF : sum_comp[31:0];
        end

        if (is_empty) begin
            o_result.action = ACT_EMPTY;
            o_result.header_byte = HDR_NONE;
            o_result.attempted = 1'b0;
        end else if (long_enough && approve) begin
            o_result.attempted = 1'b1;
            if (i_item.compressor_error) begin
                o_result.action = ACT_DROP;
                o_result.header_byte = HDR_NONE;
            end else if (17'(i_item.compressed_length) < 17'(i_item.packet_length)) begin
                o_result.action = ACT_COMPRESSED;
                o_result.header_byte = HDR_COMPRESSED;
            end else begin
                o_result.action = ACT_RAW;
                o_result.header_byte = HDR_RAW;
            end
        end else begin
            o_result.action = ACT_RAW;
            o_result.header_byte = HDR_RAW;
            o_result.attempted = 1'b0;
        end
    end

    // Gate state advances once for each request that moves to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= 1'b0;
            r_deadline <= 32'd0;
            r_total <= 32'd0;
            r_comp <= 32'd0;
        end else if (i_step) begin
            r_off <= n_off;
            r_deadline <= n_deadline;
            r_total <= n_total;
            r_comp <= n_comp;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/adaptive_compression_gate_top.sv
// Adaptive compression gate.
// Input channel: i_in_valid / o_in_ready carry one packet event request in
// i_in_data (time, plain length, compressed length, compressor error).
// Output channel: o_out_valid / i_out_ready carry one result in o_out_data
// (action, header byte, attempted flag) for every request, in order.
// Configuration: a write on i_cfg_we stores i_cfg_wdata into the register
// selected by i_cfg_idx; unknown indexes are ignored. Write only while idle.
// A request goes through the input register, then the result register; the
// decision logic between them is combinational. Throughput: one request per
// cycle while the receiver does not stall; the gate state (on/off flag,
// deadline and the two byte totals) updates as each request moves on.
// An input register and a result register separate the channels, so a new
// request is taken while a finished result still waits.
// When the receiver stalls, the result holds, the input register fills and
// o_in_ready falls; nothing is lost or repeated.
// Reset clears the gate state and both pipeline valids and loads the
// register defaults.
`default_nettype none

module adaptive_compression_gate_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [acg_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  wire logic [acg_pkg::CfgDataW-1:0]    i_cfg_wdata,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire acg_pkg::t_in_item               i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output acg_pkg::t_out_item                   o_out_data
);
    import acg_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item result;
    logic      advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.adaptive_enable <= RST_ADAPTIVE_ENABLE;
            r_cfg.min_sample_bytes <= RST_MIN_SAMPLE_BYTES;
            r_cfg.off_seconds <= RST_OFF_SECONDS;
            r_cfg.sample_seconds <= RST_SAMPLE_SECONDS;
            r_cfg.length_threshold <= RST_LENGTH_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ADAPTIVE_ENABLE: r_cfg.adaptive_enable <= i_cfg_wdata[0];
                CFG_MIN_SAMPLE_BYTES: r_cfg.min_sample_bytes <= i_cfg_wdata;
                CFG_OFF_SECONDS: r_cfg.off_seconds <= i_cfg_wdata[15:0];
                CFG_SAMPLE_SECONDS: r_cfg.sample_seconds <= i_cfg_wdata[15:0];
                CFG_LENGTH_THRESHOLD: r_cfg.length_threshold <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // A request moves on when the result register is free or being emptied.
    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
    end

    // Decision logic and gate state.
    acg_gate u_gate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_step   (advance),
        .i_item   (r_in_data),
        .o_result (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out_data;

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import acg_pkg::*;

    localparam int unsigned PIPE_LATENCY = 2;
    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned LONG_PACKETS = 20;

    // Clock, reset, the signals driven into the block and those it drives.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_idx = '0;
    logic [CfgDataW-1:0] cfg_wdata = '0;
    logic                in_valid = 1'b0;
    t_in_item            in_data = '0;
    logic                out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    t_out_item           o_out_data;

    // Gate model state and its copy of the registers.
    t_cfg        gate_cfg;
    logic        gate_off;
    logic [31:0] gate_deadline;
    logic [31:0] bytes_plain;
    logic [31:0] bytes_packed;

    // Traffic bookkeeping.
    t_in_item    packet_backlog[$];
    t_out_item   pending_results[$];
    int unsigned requests_queued = 0;
    int unsigned requests_taken = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;
    logic        steady = 1'b0;
    logic        hold_req = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    logic [31:0] traffic_sec = '0;
    logic        window_poor = 1'b0;
    t_out_item   want;

    adaptive_compression_gate_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Works out the result of one packet event and advances the gate state.
    function automatic t_out_item gate_predict(t_in_item pkt);
        t_out_item res;
        logic      approve;
        longint    savings;
        longint    floor_save;
        res = '{action: ACT_RAW, header_byte: HDR_RAW, attempted: 1'b0};
        approve = 1'b0;
        if (pkt.packet_length == 16'd0) begin
            return '{action: ACT_EMPTY, header_byte: HDR_NONE, attempted: 1'b0};
        end
        if (pkt.packet_length >= gate_cfg.length_threshold) begin
            if (!gate_cfg.adaptive_enable) begin
                approve = 1'b1;
            end else begin
                if (pkt.time_seconds >= gate_deadline) begin
                    if (!gate_off) begin
                        // Expansion gives negative savings, hence the wide signed sum.
                        savings = longint'(bytes_plain) - longint'(bytes_packed);
                        floor_save = longint'(bytes_plain / SaveDiv);
                        if (bytes_plain > gate_cfg.min_sample_bytes && savings < floor_save) begin
                            gate_off = 1'b1;
                            gate_deadline = pkt.time_seconds + gate_cfg.off_seconds;
                        end else begin
                            gate_deadline = pkt.time_seconds + gate_cfg.sample_seconds;
                        end
                    end else begin
                        gate_off = 1'b0;
                        gate_deadline = pkt.time_seconds + gate_cfg.sample_seconds;
                    end
                    bytes_plain = '0;
                    bytes_packed = '0;
                end
                approve = !gate_off;
            end
        end
        if (approve) begin
            if (pkt.compressor_error) begin
                return '{action: ACT_DROP, header_byte: HDR_NONE, attempted: 1'b1};
            end
            if (gate_cfg.adaptive_enable) begin
                bytes_plain = sat_sum(bytes_plain, {16'd0, pkt.packet_length});
                bytes_packed = sat_sum(bytes_packed, {15'd0, pkt.compressed_length});
            end
            if ({1'b0, pkt.compressed_length} < {2'b0, pkt.packet_length}) begin
                res = '{action: ACT_COMPRESSED, header_byte: HDR_COMPRESSED, attempted: 1'b1};
            end else begin
                res = '{action: ACT_RAW, header_byte: HDR_RAW, attempted: 1'b1};
            end
        end
        return res;
    endfunction

    function automatic int unsigned draw_wait();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic check_field(string what, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_val,
                     got_val);
        end
    endtask

    // Acceptance, prediction, result checking and the watchdog.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
            out_taken <= 1'b0;
            quiet_cycles = 0;
        end else begin
            in_taken <= in_valid && o_in_ready;
            out_taken <= o_out_valid && out_ready;
            if (o_out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, actual %0h", $time,
                             o_out_data);
                end else begin
                    want = pending_results.pop_front();
                    check_field("action", {6'd0, want.action}, {6'd0, o_out_data.action});
                    check_field("header_byte", want.header_byte, o_out_data.header_byte);
                    check_field("attempted", {7'd0, want.attempted},
                                {7'd0, o_out_data.attempted});
                end
            end
            if (in_valid && o_in_ready) begin
                pending_results.push_back(gate_predict(in_data));
                requests_taken++;
            end
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no request or result moved for %0d cycles", $time,
                             quiet_cycles);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Request driver: one item at a time from the backlog, with a random gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (!in_valid || in_taken) begin
                if (send_gap != 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (packet_backlog.size() != 0) begin
                    in_data <= packet_backlog.pop_front();
                    in_valid <= 1'b1;
                    send_gap = draw_wait();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls after each result, and a long hold when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            if (out_taken) begin
                stall_left = draw_wait();
            end
            if (stall_left != 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_packet(logic [31:0] sec, int unsigned plen, int unsigned clen,
                                logic err);
        t_in_item pkt;
        pkt.time_seconds = sec;
        pkt.packet_length = plen[15:0];
        pkt.compressed_length = clen[16:0];
        pkt.compressor_error = err;
        packet_backlog.push_back(pkt);
        requests_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (requests_taken != requests_queued || pending_results.size() != 0);
    endtask

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
    endtask

    // Rewrites every register once the block has gone quiet.
    task automatic set_config(logic en, logic [31:0] min_bytes, logic [15:0] off_s,
                              logic [15:0] sample_s, logic [15:0] thr);
        wait_drained();
        repeat (PIPE_LATENCY + 2) @(negedge i_clk);
        cfg_write(CFG_ADAPTIVE_ENABLE, {31'd0, en});
        cfg_write(CFG_MIN_SAMPLE_BYTES, min_bytes);
        cfg_write(CFG_OFF_SECONDS, {16'd0, off_s});
        cfg_write(CFG_SAMPLE_SECONDS, {16'd0, sample_s});
        cfg_write(CFG_LENGTH_THRESHOLD, {16'd0, thr});
        @(negedge i_clk);
        cfg_we <= 1'b0;
        gate_cfg = '{adaptive_enable: en, min_sample_bytes: min_bytes,
                     off_seconds: off_s, sample_seconds: sample_s, length_threshold: thr};
    endtask

    // Packet traffic in sampling windows: each window is either well or poorly
    // compressed, with some empty, short, huge, failed and out-of-order events.
    task automatic queue_traffic(int unsigned count);
        int unsigned pick;
        int unsigned plen;
        int unsigned clen;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                steady = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                traffic_sec = $urandom();
            end else if (pick < 6) begin
                traffic_sec = traffic_sec - $urandom_range(1, 100);
            end else if (pick < 22) begin
                traffic_sec = traffic_sec + $urandom_range(1, 3);
                window_poor = $urandom_range(0, 1);
            end else if (pick < 25) begin
                traffic_sec = traffic_sec + gate_cfg.off_seconds + $urandom_range(0, 2);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                plen = 0;
            end else if (pick < 10) begin
                plen = $urandom_range(0, 65535);
            end else if (pick < 16) begin
                plen = $urandom_range(0, gate_cfg.length_threshold);
            end else if (pick < 19) begin
                plen = 65535;
            end else begin
                plen = gate_cfg.length_threshold + $urandom_range(0, 1500);
                if (plen > 65535) begin
                    plen = 65535;
                end
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                clen = $urandom_range(0, 131071);
            end else if (pick == 1) begin
                clen = plen + $urandom_range(0, 64);
            end else if (window_poor) begin
                clen = plen - plen * $urandom_range(0, 6) / 100;
            end else begin
                clen = plen * $urandom_range(20, 90) / 100;
            end
            queue_packet(traffic_sec, plen, clen, $urandom_range(0, 15) == 0);
        end
    endtask

    // Stimulus and end of run.
    initial begin
        gate_cfg = '{adaptive_enable: RST_ADAPTIVE_ENABLE,
                     min_sample_bytes: RST_MIN_SAMPLE_BYTES,
                     off_seconds: RST_OFF_SECONDS, sample_seconds: RST_SAMPLE_SECONDS,
                     length_threshold: RST_LENGTH_THRESHOLD};
        gate_off = 1'b0;
        gate_deadline = '0;
        bytes_plain = '0;
        bytes_packed = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed events on the reset settings: empty and short packets, the
        // threshold itself, expansion, compressor failure, switching off and
        // back on, savings exactly at the limit, time running backwards and
        // the deadline wrapping past the top of the time range.
        queue_packet(32'hFFFF_FFFF, 0, 131071, 1'b1);
        queue_packet(0, 99, 10, 1'b0);
        queue_packet(0, 100, 50, 1'b0);
        queue_packet(0, 65535, 65535, 1'b0);
        queue_packet(1, 65535, 131071, 1'b0);
        queue_packet(1, 500, 20, 1'b1);
        queue_packet(2, 1000, 900, 1'b0);
        queue_packet(30, 2000, 10, 1'b0);
        queue_packet(62, 2000, 10, 1'b0);
        queue_packet(64, 300, 200, 1'b0);
        queue_packet(66, 1200, 1190, 1'b0);
        queue_packet(68, 100, 100, 1'b0);
        queue_packet(10, 200, 100, 1'b0);
        queue_packet(32'hFFFF_FFFF, 200, 100, 1'b0);
        queue_packet(0, 200, 100, 1'b1);
        queue_packet(5, 65535, 0, 1'b0);
        queue_packet(7, 1, 0, 1'b0);
        queue_packet(7, 2000, 1900, 1'b0);
        queue_packet(9, 200, 100, 1'b0);
        queue_packet(11, 2000, 1901, 1'b0);
        queue_packet(13, 200, 100, 1'b0);
        queue_packet(14, 65535, 1, 1'b0);

        // Large expanding packets back to back inside one long window.
        set_config(1'b1, RST_MIN_SAMPLE_BYTES, RST_OFF_SECONDS, 16'hFFFF, 16'd0);
        steady = 1'b1;
        queue_packet(100, 65535, 131071, 1'b0);
        for (int unsigned n = 0; n < LONG_PACKETS; n++) begin
            queue_packet(100, 65535, 131071, 1'b0);
        end
        queue_packet(100 + 65535, 65535, 1000, 1'b0);
        queue_packet(100 + 65536, 65535, 1000, 1'b0);

        // Random traffic over a range of settings, extremes included.
        set_config(RST_ADAPTIVE_ENABLE, RST_MIN_SAMPLE_BYTES, RST_OFF_SECONDS,
                   RST_SAMPLE_SECONDS, RST_LENGTH_THRESHOLD);
        traffic_sec = 200;
        queue_traffic(100);
        @(posedge i_clk);
        hold_req = 1'b1;

        set_config(1'b0, 32'd0, 16'd0, 16'd0, 16'd0);
        queue_traffic(100);

        set_config(1'b1, 32'd0, 16'd0, 16'd0, 16'd0);
        queue_traffic(50);
        wait_drained();
        queue_traffic(50);

        set_config(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_traffic(100);

        set_config(1'b1, $urandom_range(0, 5000), $urandom_range(1, 20),
                   $urandom_range(1, 5), $urandom_range(0, 1500));
        queue_traffic(100);

        set_config(1'b1, $urandom_range(0, 5000), $urandom_range(0, 20),
                   $urandom_range(0, 5), $urandom_range(0, 1500));
        queue_traffic(100);

        set_config(1'b1, 32'd200, 16'd3, 16'd1, 16'd64);
        queue_traffic(100);

        wait_drained();
        repeat (PIPE_LATENCY + 6) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/acg_pkg.sv
hdl/acg_gate.sv
hdl/adaptive_compression_gate_top.sv
tb/tb_top.sv
